FILE: sv/akac_pkg.sv
// Package: shared types, constants and register codes for the key actuation core.
package akac_pkg;

   localparam int KEY_COUNT  = 64;
   localparam int KEY_IDX_W  = 6;
   localparam int ADDR_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int TRAVEL_W   = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // actuation modes
   localparam logic [MODE_W-1:0] MODE_STATIC     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAPID      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTUATION_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_POINT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_MARGIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_MARGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DELTA    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DELTA  = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0]   actuation_mode;
      logic [TRAVEL_W-1:0] trip_point;
      logic [TRAVEL_W-1:0] press_margin;
      logic [TRAVEL_W-1:0] release_margin;
      logic [TRAVEL_W-1:0] press_delta;
      logic [TRAVEL_W-1:0] release_delta;
   } cfg_type;

   // per-key stored state
   typedef struct packed {
      logic                pressed;
      logic [TRAVEL_W-1:0] extremum;
      logic                armed;
   } key_state_type;

endpackage

FILE: sv/akac_channels.sv
// Interfaces: sample request, key result and configuration write channels.
interface akac_req_if;
   import akac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KEY_IDX_W-1:0] key_index;
   logic [TRAVEL_W-1:0]  travel;
   modport source (output valid, output key_index, output travel, input ready);
   modport sink   (input valid, input key_index, input travel, output ready);
endinterface

interface akac_rsp_if;
   import akac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KEY_IDX_W-1:0] key_number;
   logic                 pressed;
   logic                 changed;
   modport source (output valid, output key_number, output pressed, output changed,
                   input ready);
   modport sink   (input valid, input key_number, input pressed, input changed,
                   output ready);
endinterface

interface akac_csr_if;
   import akac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/akac_key_update.sv
// Per-key next-state logic for static, rapid and continuous rapid trigger.
module akac_key_update (
   input  akac_pkg::cfg_type                 cfg,
   input  logic [akac_pkg::TRAVEL_W-1:0]     travel,
   input  akac_pkg::key_state_type           cur,
   output akac_pkg::key_state_type           nxt
);
   import akac_pkg::*;

   logic [TRAVEL_W:0] v_w;
   logic [TRAVEL_W:0] ext_w;
   logic [TRAVEL_W:0] ap_w;
   logic              above_point;
   logic              static_release;
   logic              static_press;
   logic              rise;
   logic              fall;
   logic              rapid_release;
   logic              rapid_press;
   key_state_type     rapid;

   // 9-bit unsigned sums stand in for the signed, clamped levels
   assign v_w         = {1'b0, travel};
   assign ext_w       = {1'b0, cur.extremum};
   assign ap_w        = {1'b0, cfg.trip_point};
   assign above_point = v_w > ap_w;

   assign static_release = (v_w + {1'b0, cfg.release_margin}) < ap_w;
   assign static_press   = v_w > (ap_w + {1'b0, cfg.press_margin});

   assign rise          = v_w > ext_w;
   assign fall          = v_w < ext_w;
   assign rapid_release = (v_w + {1'b0, cfg.release_delta}) < ext_w;
   assign rapid_press   = v_w > (ext_w + {1'b0, cfg.press_delta});

   always_comb begin
      rapid = cur;
      if (cur.pressed) begin
         if (rise) begin
            rapid.extremum = travel;
         end else if (rapid_release) begin
            rapid.pressed  = 1'b0;
            rapid.extremum = travel;
         end
      end else begin
         if (fall) begin
            rapid.extremum = travel;
         end else if (rapid_press) begin
            rapid.pressed  = 1'b1;
            rapid.extremum = travel;
         end
      end
   end

   always_comb begin
      nxt = cur;
      case (cfg.actuation_mode)
         MODE_STATIC: begin
            if (cur.pressed) begin
               if (static_release) nxt.pressed = 1'b0;
            end else begin
               if (static_press) nxt.pressed = 1'b1;
            end
         end
         MODE_RAPID: begin
            if (above_point) begin
               nxt = rapid;
            end else begin
               nxt.pressed = 1'b0;
               if (rise) nxt.extremum = travel;
            end
         end
         MODE_CONTINUOUS: begin
            if (cur.armed) begin
               nxt = rapid;
               if (travel == '0) begin
                  nxt = '0;
               end
            end else if (above_point) begin
               nxt.pressed  = 1'b1;
               nxt.extremum = travel;
               nxt.armed    = 1'b1;
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule

FILE: sv/analog_key_actuation_core.sv
// Top level: analog key actuation core with per-key state memory.
//
// Usage:
//  - req_chan carries one travel sample (key_index, travel) per transfer.
//  - rsp_chan returns one result per sample, in order: key_number, the
//    pressed state after the sample, and changed when it flipped.
//  - csr_chan writes a configuration register (index, data); always ready.
//    Write only while no sample is in flight. Indexes above five are dropped.
//  - A sample goes through the sample stage and the result register to
//    rsp_chan. Throughput without stalls: one sample per cycle, back to
//    back, even for repeats of one key (bypass from the write-back path).
//  - Per-key state sits in a KEY_COUNT-entry memory with registered read; a
//    row of valid flops makes unwritten keys read as all zero, so reset is
//    immediate with no clearing pass.
//  - Reset: configuration returns to its defaults, all keys read released,
//    the pipeline empties.
//  - When the receiver stalls, the result register holds, the sample stage
//    holds behind it, and req_chan.ready drops once both are full.
module analog_key_actuation_core (
   input logic        clock,
   input logic        reset,
   akac_req_if.sink   req_chan,
   akac_rsp_if.source rsp_chan,
   akac_csr_if.sink   csr_chan
);
   import akac_pkg::*;

   // configuration
   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    csr_write;

   // sample stage (after acceptance, state read in flight)
   logic                 stage_valid_ff;
   logic                 stage_valid_in;
   logic [KEY_IDX_W-1:0] stage_key_ff;
   logic [TRAVEL_W-1:0]  stage_travel_ff;

   // memory read and bypass
   key_state_type        key_mem [KEY_COUNT];
   logic [KEY_COUNT-1:0] key_valid_ff;
   key_state_type        rd_data_ff;
   logic                 rd_valid_ff;
   logic                 fwd_ff;
   key_state_type        fwd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;

   // update
   key_state_type cur_state;
   key_state_type nxt_state;
   logic          in_range;
   logic          wr_en;
   logic          advance;
   logic          req_accept;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [KEY_IDX_W-1:0] rsp_key_ff;
   logic                 rsp_pressed_ff;
   logic                 rsp_changed_ff;

   // ---------------- configuration port ----------------
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid & csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_chan.index)
            CSR_ACTUATION_MODE: cfg_in.actuation_mode = csr_chan.data[MODE_W-1:0];
            CSR_TRIP_POINT:     cfg_in.trip_point     = csr_chan.data;
            CSR_PRESS_MARGIN:   cfg_in.press_margin   = csr_chan.data;
            CSR_RELEASE_MARGIN: cfg_in.release_margin = csr_chan.data;
            CSR_PRESS_DELTA:    cfg_in.press_delta    = csr_chan.data;
            CSR_RELEASE_DELTA:  cfg_in.release_delta  = csr_chan.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.actuation_mode <= MODE_STATIC;
         cfg_ff.trip_point     <= 8'd128;
         cfg_ff.press_margin   <= 8'd0;
         cfg_ff.release_margin <= 8'd0;
         cfg_ff.press_delta    <= 8'd8;
         cfg_ff.release_delta  <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- handshake ----------------
   // stage moves into the result register when that is empty or draining
   assign advance        = stage_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~stage_valid_ff | advance;
   assign req_accept     = req_chan.valid & req_chan.ready;

   assign stage_valid_in = req_accept | (stage_valid_ff & ~advance);
   assign rsp_valid_in   = advance | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_key_ff    <= req_chan.key_index;
         stage_travel_ff <= req_chan.travel;
      end
   end

   // ---------------- state memory ----------------
   assign rd_addr  = req_chan.key_index[ADDR_W-1:0];
   assign wr_addr  = stage_key_ff[ADDR_W-1:0];
   assign in_range = int'(stage_key_ff) < KEY_COUNT;
   assign wr_en    = advance & in_range;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= nxt_state;
      end
      if (req_accept) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   // valid row: an unwritten key reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
      end else if (wr_en) begin
         key_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // bypass: the previous sample of the same key is written this edge
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_valid_ff <= key_valid_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= nxt_state;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         cur_state = fwd_data_ff;
      end else if (rd_valid_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   // ---------------- update ----------------
   akac_key_update u_update (
      .cfg    (cfg_ff),
      .travel (stage_travel_ff),
      .cur    (cur_state),
      .nxt    (nxt_state)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_key_ff     <= stage_key_ff;
         rsp_pressed_ff <= in_range & nxt_state.pressed;
         rsp_changed_ff <= in_range & (nxt_state.pressed ^ cur_state.pressed);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.key_number = rsp_key_ff;
   assign rsp_chan.pressed    = rsp_pressed_ff;
   assign rsp_chan.changed    = rsp_changed_ff;

endmodule
